[src/ccpg_pkg.sv]
`timescale 1ns / 1ps

package ccpg_pkg;

    // Angle counter range
    localparam int unsigned ANGLE_STEPS = 720;
    localparam int unsigned ANGLE_W     = 10;
    localparam logic [ANGLE_W-1:0] ANGLE_LAST = 10'(ANGLE_STEPS - 1);

    // Crank tooth numbering and gaps (tooth index y = count/6 + 1)
    localparam logic [6:0] GAP_A_LO = 7'd58;
    localparam logic [6:0] GAP_A_HI = 7'd59;
    localparam logic [6:0] GAP_B_LO = 7'd118;
    localparam logic [6:0] GAP_B_HI = 7'd119;
    localparam logic [6:0] CAM1X_LO = 7'd56;
    localparam logic [6:0] CAM1X_HI = 7'd74;

    // Knock windows: base + pitch * cylinder + offset
    localparam int unsigned KNOCK_CYL   = 4;
    localparam int unsigned KNOCK_BASE  = 120;
    localparam int unsigned KNOCK_PITCH = 180;
    localparam int unsigned KNOCK_W     = 12;

    // Configuration
    localparam int unsigned CFG_WDATA_W  = 10;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam logic [9:0]  SPAN_RESET   = 10'd20;

    typedef logic [ANGLE_W-1:0] angle_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAM_ADVANCE  = 2'd0,
        CFG_KNOCK_OFFSET = 2'd1,
        CFG_KNOCK_SPAN   = 2'd2,
        CFG_KNOCK_MASK   = 2'd3
    } cfg_idx_t;

    // Angle tracker view handed to the result stage
    typedef struct packed {
        angle_t count;
        logic   crank;
        logic   cam_single;
    } angle_state_t;

endpackage

[src/ccpg_angle.sv]
`timescale 1ns / 1ps

module ccpg_angle (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    output ccpg_pkg::angle_state_t state_next
);

    ccpg_pkg::angle_t count_reg;
    logic [1:0]       mod3_reg;
    logic [7:0]       div3_reg;
    logic             crank_reg;
    logic             cam_single_reg;

    ccpg_pkg::angle_t count_next;
    logic [1:0]       mod3_next;
    logic [7:0]       div3_next;
    logic             crank_next;
    logic             cam_single_next;
    logic [6:0]       tooth;
    logic             gap;
    logic             wrap;

    // Advance the counter with its running quotient and remainder by three
    always_comb
    begin
        wrap       = (count_reg == ccpg_pkg::ANGLE_LAST);
        count_next = count_reg;
        mod3_next  = mod3_reg;
        div3_next  = div3_reg;
        if (step)
        begin
            count_next = wrap ? '0 : count_reg + 10'd1;
            mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            if (wrap)
            begin
                div3_next = '0;
            end
            else if (mod3_reg == 2'd2)
            begin
                div3_next = div3_reg + 8'd1;
            end
        end
    end

    // Recompute crank and cam-1x levels on every third step, hold otherwise
    always_comb
    begin
        tooth = 7'(div3_next[7:1]) + 7'd1;
        gap   = ((tooth >= ccpg_pkg::GAP_A_LO) && (tooth <= ccpg_pkg::GAP_A_HI)) ||
                ((tooth >= ccpg_pkg::GAP_B_LO) && (tooth <= ccpg_pkg::GAP_B_HI));
        crank_next      = crank_reg;
        cam_single_next = cam_single_reg;
        if (step && (mod3_next == 2'd0))
        begin
            crank_next      = !(div3_next[0] && !gap);
            cam_single_next = (tooth >= ccpg_pkg::CAM1X_LO) &&
                              (tooth <= ccpg_pkg::CAM1X_HI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            mod3_reg       <= '0;
            div3_reg       <= '0;
            crank_reg      <= 1'b0;
            cam_single_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            mod3_reg       <= mod3_next;
            div3_reg       <= div3_next;
            crank_reg      <= crank_next;
            cam_single_reg <= cam_single_next;
        end
    end

    assign state_next.count      = count_next;
    assign state_next.crank      = crank_next;
    assign state_next.cam_single = cam_single_next;

endmodule

[src/ccpg_cam.sv]
`timescale 1ns / 1ps

module ccpg_cam (
    input  ccpg_pkg::angle_t count,
    input  logic [7:0]       advance,
    output logic             intake,
    output logic             exhaust
);

    logic [10:0] isum;
    logic [9:0]  ediff;
    logic        eneg;

    // Intake windows on count plus advance, no wrap
    always_comb
    begin
        isum   = {1'b0, count} + {3'b000, advance};
        intake = ((isum >= 11'd132) && (isum <= 11'd264)) ||
                 ((isum >= 11'd312) && (isum <= 11'd444)) ||
                 ((isum >= 11'd492) && (isum <= 11'd528)) ||
                 ((isum >= 11'd672) && (isum <= 11'd708));
    end

    // Exhaust windows on count minus advance; a negative difference never matches
    always_comb
    begin
        eneg    = (count < {2'b00, advance});
        ediff   = count - {2'b00, advance};
        exhaust = !eneg &&
                  (((ediff >= 10'd72)  && (ediff <= 10'd204)) ||
                   ((ediff >= 10'd252) && (ediff <= 10'd384)) ||
                   ((ediff >= 10'd432) && (ediff <= 10'd468)) ||
                   ((ediff >= 10'd612) && (ediff <= 10'd648)));
    end

endmodule

[src/ccpg_knock.sv]
`timescale 1ns / 1ps

module ccpg_knock (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  ccpg_pkg::angle_t             count,
    input  logic [9:0]                   offset,
    input  logic [9:0]                   span,
    input  logic [ccpg_pkg::KNOCK_CYL-1:0] mask,
    output logic                         knock_next
);

    logic                                knock_reg;
    logic [ccpg_pkg::KNOCK_CYL-1:0]      hit;
    logic [ccpg_pkg::KNOCK_W-1:0]        lo [ccpg_pkg::KNOCK_CYL];
    logic [ccpg_pkg::KNOCK_W-1:0]        hi [ccpg_pkg::KNOCK_CYL];

    // Test each enabled cylinder window against the new count
    always_comb
    begin
        for (int c = 0; c < ccpg_pkg::KNOCK_CYL; c++)
        begin
            lo[c]  = ccpg_pkg::KNOCK_W'(ccpg_pkg::KNOCK_BASE + ccpg_pkg::KNOCK_PITCH * c) +
                     ccpg_pkg::KNOCK_W'(offset);
            hi[c]  = lo[c] + ccpg_pkg::KNOCK_W'(span);
            hit[c] = mask[c] &&
                     (ccpg_pkg::KNOCK_W'(count) >= lo[c]) &&
                     (ccpg_pkg::KNOCK_W'(count) <= hi[c]);
        end
    end

    // Raise on any hit, drop if enabled but missed, hold with nothing enabled
    always_comb
    begin
        knock_next = knock_reg;
        if (step)
        begin
            if (|hit)
            begin
                knock_next = 1'b1;
            end
            else if (|mask)
            begin
                knock_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knock_reg <= 1'b0;
        end
        else
        begin
            knock_reg <= knock_next;
        end
    end

endmodule

[src/crank_cam_pattern_generator_top.sv]
`timescale 1ns / 1ps
// Channel  | Signals                                   | Direction
// request  | req_valid, req_stall, tick                | in (stall out)
// response | rsp_valid, rsp_stall, angle_step, pins    | out (stall in)
// config   | cfg_we, cfg_index, cfg_wdata              | in
//
// A request is registered in the input register, then evaluated and stored in the
// response register; one request per cycle is sustained while rsp_stall is low.
// The combinational evaluation (counter step, window compares, knock adds)
// between the two registers sets the rate.
// Reset clears counter, levels, valids and config registers to their defaults.
// req_stall rises only while a request waits and the response is stalled.

module crank_cam_pattern_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                tick,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [9:0]                          angle_step,
    output logic                                crank_pin,
    output logic                                cam_single_pin,
    output logic                                cam_intake_pin,
    output logic                                cam_exhaust_pin,
    output logic                                knock_on,
    input  logic                                cfg_we,
    input  logic [ccpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccpg_pkg::CFG_WDATA_W-1:0]    cfg_wdata
);

    logic [7:0]                     cam_advance_reg;
    logic [9:0]                     knock_offset_reg;
    logic [9:0]                     knock_span_reg;
    logic [ccpg_pkg::KNOCK_CYL-1:0] knock_mask_reg;

    logic                           req_valid_reg;
    logic                           tick_reg;
    logic                           rsp_valid_reg;
    logic                           eval;
    logic                           step;

    ccpg_pkg::angle_state_t         angle_nxt;
    logic                           intake;
    logic                           exhaust;
    logic                           knock_nxt;

    // Hold configuration registers; the user must write only while idle (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_advance_reg  <= '0;
            knock_offset_reg <= '0;
            knock_span_reg   <= ccpg_pkg::SPAN_RESET;
            knock_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (ccpg_pkg::cfg_idx_t'(cfg_index))
                ccpg_pkg::CFG_CAM_ADVANCE:  cam_advance_reg  <= cfg_wdata[7:0];
                ccpg_pkg::CFG_KNOCK_OFFSET: knock_offset_reg <= cfg_wdata;
                ccpg_pkg::CFG_KNOCK_SPAN:   knock_span_reg   <= cfg_wdata;
                ccpg_pkg::CFG_KNOCK_MASK:   knock_mask_reg   <= cfg_wdata[3:0];
                default:                    ;
            endcase
        end
    end

    // Evaluate the held request when the response register is free
    assign eval      = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign step      = eval && tick_reg;
    assign req_stall = req_valid_reg && !eval;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_valid_reg || eval)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            tick_reg <= tick;
        end
    end

    ccpg_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .state_next (angle_nxt)
    );

    ccpg_cam u_cam (
        .count   (angle_nxt.count),
        .advance (cam_advance_reg),
        .intake  (intake),
        .exhaust (exhaust)
    );

    ccpg_knock u_knock (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .count      (angle_nxt.count),
        .offset     (knock_offset_reg),
        .span       (knock_span_reg),
        .mask       (knock_mask_reg),
        .knock_next (knock_nxt)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eval)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            angle_step      <= angle_nxt.count;
            crank_pin       <= angle_nxt.crank;
            cam_single_pin  <= angle_nxt.cam_single;
            cam_intake_pin  <= intake;
            cam_exhaust_pin <= exhaust;
            knock_on        <= knock_nxt;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[src/ccpg_checker.sv]
`timescale 1ns / 1ps

module ccpg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [9:0] angle_step,
    input logic       cam_intake_pin,
    input logic       cam_exhaust_pin
);

    // Response must persist while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // Back-pressure only comes from a stalled full response register
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without downstream stall");

    // Counter stays inside one engine cycle
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> angle_step <= 10'd719)
        else $error("angle out of range");

    // Intake level implies the counter is at most the last intake bound
    a_intake_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && cam_intake_pin |-> angle_step <= 10'd708)
        else $error("intake level past last window");

    // Exhaust level implies the counter reaches the first exhaust bound
    a_exhaust_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && cam_exhaust_pin |-> angle_step >= 10'd72)
        else $error("exhaust level before first window");

endmodule

bind crank_cam_pattern_generator_top ccpg_checker u_ccpg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_stall       (req_stall),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .angle_step      (angle_step),
    .cam_intake_pin  (cam_intake_pin),
    .cam_exhaust_pin (cam_exhaust_pin)
);
